### hw/rtl/dual_stepper_phase_sequencer_unit_assert.svh
// assertion macros for the stepper sequencer
`ifndef DUAL_STEPPER_PHASE_SEQUENCER_UNIT_ASSERT_SVH
`define DUAL_STEPPER_PHASE_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define DSPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DSPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/dsps_pkg.sv
`timescale 1ns / 1ps

package dsps_pkg;

    localparam int UNIT_W    = 16;
    localparam int MAXHOME_W = 20;
    localparam int WAIT_W    = 16;
    localparam int TARGET_W  = 24;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_HOME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POST_HOME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_A     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_B     = 3'd4;

    localparam logic [UNIT_W-1:0]    UNIT_STEP_RST = 16'd200;
    localparam logic [MAXHOME_W-1:0] MAX_HOME_RST  = 20'd5000;
    localparam logic [WAIT_W-1:0]    POST_HOME_RST = 16'd500;

    localparam logic [WAIT_W-1:0] POLL_WAIT   = 16'd10;
    localparam logic [WAIT_W-1:0] SETTLE_WAIT = 16'd100;

    localparam logic [3:0] COIL_P0 = 4'b0101;
    localparam logic [3:0] COIL_P1 = 4'b0110;
    localparam logic [3:0] COIL_P2 = 4'b1010;
    localparam logic [3:0] COIL_P3 = 4'b1001;

    typedef struct packed {
        logic [UNIT_W-1:0]    unit_step;
        logic [MAXHOME_W-1:0] max_home_ticks;
        logic [WAIT_W-1:0]    post_home_ticks;
        logic                 dir_a;
        logic                 dir_b;
    } t_cfg;

    typedef struct packed {
        logic [3:0] coils;
        logic       homing;
        logic       fail;
    } t_chan_res;

    typedef struct packed {
        t_chan_res a;
        t_chan_res b;
    } t_result;

    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = COIL_P0;
            2'd1:    pat = COIL_P1;
            2'd2:    pat = COIL_P2;
            default: pat = COIL_P3;
        endcase
        return pat;
    endfunction

endpackage

### hw/rtl/dual_stepper_phase_sequencer_unit.sv
// two-channel full-step stepper sequencer with sensor homing
// input channel: i_in_valid / o_in_ready carries one request (tick, set target,
// start homing) with both end-sensor levels; output channel: o_out_valid /
// i_out_ready returns one result per request: coil bits, homing flags and
// timeout pulses of both channels
// result: registered into the output buffer when the request is accepted
// throughput: one request per cycle while o_in_ready is high; all channel work
// is a single combinational pass from state registers into the result register
// a two-entry output buffer (result register plus skid) keeps requests flowing
// while the receiver stalls; o_in_ready drops only once both entries are full
// configuration: i_cfg_we writes register i_cfg_idx with i_cfg_wdata at once
// (0 unit step, 1 homing limit, 2 post-homing wait, 3 dir a, 4 dir b)
// reset (synchronous, active low): counts, phases and coils clear, homing
// idles, registers return to 200 / 5000 / 500 / 1 / 1, output buffer empties
`timescale 1ns / 1ps

`include "dual_stepper_phase_sequencer_unit_assert.svh"

module dual_stepper_phase_sequencer_unit #(
    parameter int COUNT_BITS   = 24,
    parameter int ELAPSED_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_opcode,
    input  logic                                  i_channel,
    input  logic signed [dsps_pkg::TARGET_W-1:0]  i_target_steps,
    input  logic                                  i_sensor_a,
    input  logic                                  i_sensor_b,
    input  logic                                  i_cfg_we,
    input  logic [dsps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dsps_pkg::CFG_W-1:0]            i_cfg_wdata,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [3:0]                            o_coils_a,
    output logic [3:0]                            o_coils_b,
    output logic                                  o_homing_a,
    output logic                                  o_homing_b,
    output logic                                  o_home_fail_a,
    output logic                                  o_home_fail_b
);

    dsps_pkg::t_cfg    r_cfg;
    dsps_pkg::t_result res;
    dsps_pkg::t_result out_data;
    logic              accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_step       <= dsps_pkg::UNIT_STEP_RST;
            r_cfg.max_home_ticks  <= dsps_pkg::MAX_HOME_RST;
            r_cfg.post_home_ticks <= dsps_pkg::POST_HOME_RST;
            r_cfg.dir_a           <= 1'b1;
            r_cfg.dir_b           <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dsps_pkg::REG_UNIT_STEP: r_cfg.unit_step <= i_cfg_wdata[dsps_pkg::UNIT_W-1:0];
                dsps_pkg::REG_MAX_HOME:  r_cfg.max_home_ticks <= i_cfg_wdata;
                dsps_pkg::REG_POST_HOME:
                    r_cfg.post_home_ticks <= i_cfg_wdata[dsps_pkg::WAIT_W-1:0];
                dsps_pkg::REG_DIR_A:     r_cfg.dir_a <= i_cfg_wdata[0];
                dsps_pkg::REG_DIR_B:     r_cfg.dir_b <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    dsps_channel #(
        .COUNT_BITS   (COUNT_BITS),
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_chan_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_opcode),
        .i_sel    (!i_channel),
        .i_target (i_target_steps),
        .i_sensor (i_sensor_a),
        .i_dir    (r_cfg.dir_a),
        .i_cfg    (r_cfg),
        .o_res    (res.a)
    );

    dsps_channel #(
        .COUNT_BITS   (COUNT_BITS),
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_chan_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_opcode),
        .i_sel    (i_channel),
        .i_target (i_target_steps),
        .i_sensor (i_sensor_b),
        .i_dir    (r_cfg.dir_b),
        .i_cfg    (r_cfg),
        .o_res    (res.b)
    );

    dsps_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (res),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_ready (i_out_ready)
    );

    assign o_coils_a     = out_data.a.coils;
    assign o_coils_b     = out_data.b.coils;
    assign o_homing_a    = out_data.a.homing;
    assign o_homing_b    = out_data.b.homing;
    assign o_home_fail_a = out_data.a.fail;
    assign o_home_fail_b = out_data.b.fail;

    `DSPS_ASSERT_NOW(a_full_has_main, i_clk, i_rst_n, !o_in_ready, o_out_valid)
    `DSPS_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        accept && o_out_valid && !i_out_ready, !o_in_ready)
    `DSPS_ASSERT_NOW(a_fail_ends_homing, i_clk, i_rst_n,
        o_out_valid && (o_home_fail_a || o_home_fail_b),
        !(o_home_fail_a && o_homing_a) && !(o_home_fail_b && o_homing_b))
    `DSPS_ASSERT_NOW(a_coil_pattern, i_clk, i_rst_n, o_out_valid,
        (o_coils_a == 4'd0 || o_coils_a == dsps_pkg::COIL_P0 ||
         o_coils_a == dsps_pkg::COIL_P1 || o_coils_a == dsps_pkg::COIL_P2 ||
         o_coils_a == dsps_pkg::COIL_P3))

endmodule

### hw/rtl/dsps_channel.sv
`timescale 1ns / 1ps

module dsps_channel #(
    parameter int COUNT_BITS   = 24,
    parameter int ELAPSED_BITS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [1:0]                           i_op,
    input  logic                                 i_sel,
    input  logic signed [dsps_pkg::TARGET_W-1:0] i_target,
    input  logic                                 i_sensor,
    input  logic                                 i_dir,
    input  dsps_pkg::t_cfg                       i_cfg,
    output dsps_pkg::t_chan_res                  o_res
);

    localparam int EXT_W = 34;
    localparam int CMP_W = (ELAPSED_BITS > dsps_pkg::MAXHOME_W) ? ELAPSED_BITS
                                                                 : dsps_pkg::MAXHOME_W;
    localparam logic signed [EXT_W-1:0] CNT_HI =
        EXT_W'((64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] CNT_LO = -CNT_HI - EXT_W'(1);
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POLL,
        ST_SETTLE,
        ST_POST
    } t_mode;

    function automatic logic signed [COUNT_BITS-1:0] sat_cnt(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] r;
        if (v > CNT_HI) begin
            r = CNT_HI;
        end else if (v < CNT_LO) begin
            r = CNT_LO;
        end else begin
            r = v;
        end
        return r[COUNT_BITS-1:0];
    endfunction

    t_mode                          r_mode, n_mode;
    logic signed [COUNT_BITS-1:0]   r_rem, n_rem;
    logic [1:0]                     r_phase, n_phase;
    logic [dsps_pkg::WAIT_W-1:0]    r_wait, n_wait;
    logic [ELAPSED_BITS-1:0]        r_elapsed, n_elapsed;
    logic [3:0]                     r_latch, n_latch;
    logic                           fail;
    logic [dsps_pkg::WAIT_W-1:0]    wait_dec;
    logic                           step_up;
    logic signed [COUNT_BITS-1:0]   unit_sat;
    logic signed [COUNT_BITS-1:0]   back_sat;
    logic signed [COUNT_BITS-1:0]   target_sat;

    assign unit_sat   = sat_cnt($signed(EXT_W'(i_cfg.unit_step)));
    assign back_sat   = sat_cnt(-$signed(EXT_W'(i_cfg.unit_step >> 1)));
    assign target_sat = sat_cnt(EXT_W'(i_target));

    always_comb begin
        n_mode    = r_mode;
        n_rem     = r_rem;
        n_phase   = r_phase;
        n_wait    = r_wait;
        n_elapsed = r_elapsed;
        n_latch   = r_latch;
        fail      = 1'b0;
        wait_dec  = (r_wait != '0) ? r_wait - 1'b1 : '0;
        step_up   = 1'b0;
        unique case (i_op)
            dsps_pkg::OP_TICK: begin
                if (r_mode != ST_IDLE) begin
                    if (r_mode == ST_POLL && r_elapsed != ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    n_wait = wait_dec;
                    if (wait_dec == '0) begin
                        unique case (r_mode)
                            ST_POLL: begin
                                if (CMP_W'(n_elapsed) > CMP_W'(i_cfg.max_home_ticks)) begin
                                    n_mode = ST_IDLE;
                                    fail   = 1'b1;
                                end else if (i_sensor) begin
                                    n_rem  = unit_sat;
                                    n_wait = dsps_pkg::POLL_WAIT;
                                    n_mode = ST_POLL;
                                end else begin
                                    n_wait = dsps_pkg::SETTLE_WAIT;
                                    n_mode = ST_SETTLE;
                                end
                            end
                            ST_SETTLE: begin
                                n_rem  = back_sat;
                                n_wait = i_cfg.post_home_ticks;
                                n_mode = (i_cfg.post_home_ticks == '0) ? ST_IDLE : ST_POST;
                            end
                            ST_POST: begin
                                n_mode = ST_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
                // step after the homing update
                if (n_rem == '0) begin
                    n_latch = '0;
                end else begin
                    n_latch = dsps_pkg::coil_pattern(r_phase);
                    if (!n_rem[COUNT_BITS-1]) begin
                        n_rem   = n_rem - 1'b1;
                        step_up = i_dir;
                    end else begin
                        n_rem   = n_rem + 1'b1;
                        step_up = !i_dir;
                    end
                    n_phase = step_up ? r_phase + 2'd1 : r_phase - 2'd1;
                end
            end
            dsps_pkg::OP_SET: begin
                if (i_sel && r_mode == ST_IDLE) begin
                    n_rem = target_sat;
                end
            end
            dsps_pkg::OP_HOME: begin
                if (i_sel) begin
                    n_elapsed = '0;
                    if (i_sensor) begin
                        n_rem  = unit_sat;
                        n_wait = dsps_pkg::POLL_WAIT;
                        n_mode = ST_POLL;
                    end else begin
                        n_wait = dsps_pkg::SETTLE_WAIT;
                        n_mode = ST_SETTLE;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_res.coils  = n_latch;
    assign o_res.homing = (n_mode != ST_IDLE);
    assign o_res.fail   = fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ST_IDLE;
            r_rem     <= '0;
            r_phase   <= '0;
            r_wait    <= '0;
            r_elapsed <= '0;
            r_latch   <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_rem     <= n_rem;
            r_phase   <= n_phase;
            r_wait    <= n_wait;
            r_elapsed <= n_elapsed;
            r_latch   <= n_latch;
        end
    end

endmodule

### hw/rtl/dsps_out_buf.sv
`timescale 1ns / 1ps

module dsps_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dsps_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output dsps_pkg::t_result o_data,
    input  logic              i_ready
);

    logic              r_main_valid;
    logic              r_skid_valid;
    dsps_pkg::t_result r_main;
    dsps_pkg::t_result r_skid;
    logic              take;

    assign take    = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take && r_skid_valid) begin
            r_main       <= r_skid;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_main_valid <= i_push;
            if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main       <= i_data;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

### tb/tb_dual_stepper_phase_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_dual_stepper_phase_sequencer_unit;

    localparam int TARGET_W  = dsps_pkg::TARGET_W;
    localparam int WAIT_W    = dsps_pkg::WAIT_W;
    localparam int UNIT_W    = dsps_pkg::UNIT_W;
    localparam int MAXHOME_W = dsps_pkg::MAXHOME_W;
    localparam int CFG_W     = dsps_pkg::CFG_W;
    localparam int CFG_IDX_W = dsps_pkg::CFG_IDX_W;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int CH_A = 0;
    localparam int CH_B = 1;
    localparam logic [15:0] COIL_SEQ = {dsps_pkg::COIL_P3, dsps_pkg::COIL_P2,
                                        dsps_pkg::COIL_P1, dsps_pkg::COIL_P0};
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 90;

    typedef enum logic [1:0] {HM_IDLE, HM_POLL, HM_SETTLE, HM_POST} t_home_mode;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic                       channel;
        logic signed [TARGET_W-1:0] target;
        logic                       sensor_a;
        logic                       sensor_b;
    } t_request;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [1:0]                 i_opcode = dsps_pkg::OP_TICK;
    logic                       i_channel = 1'b0;
    logic signed [TARGET_W-1:0] i_target_steps = '0;
    logic                       i_sensor_a = 1'b0;
    logic                       i_sensor_b = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = dsps_pkg::REG_UNIT_STEP;
    logic [CFG_W-1:0]           i_cfg_wdata = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [3:0]                 o_coils_a;
    logic [3:0]                 o_coils_b;
    logic                       o_homing_a;
    logic                       o_homing_b;
    logic                       o_home_fail_a;
    logic                       o_home_fail_b;

    dual_stepper_phase_sequencer_unit DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic signed [TARGET_W-1:0] step_cnt [2];
    logic [1:0]                 phase_q [2];
    t_home_mode                 home_st [2];
    logic [WAIT_W-1:0]          home_delay [2];
    logic [19:0]                home_age [2];
    logic [3:0]                 coil_latch [2];
    logic                       dir_cfg [2];
    logic [UNIT_W-1:0]          cfg_unit;
    logic [MAXHOME_W-1:0]       cfg_max_home;
    logic [WAIT_W-1:0]          cfg_post;

    t_request          cmd_q [$];
    dsps_pkg::t_result drive_expect_q [$];

    int  mismatch_n = 0;
    int  accepted_n = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  quiet = 1'b0;
    logic sticky_sa = 1'b1;
    logic sticky_sb = 1'b1;

    function automatic void start_poll(input int c, input logic sensor);
        if (sensor) begin
            step_cnt[c] = $signed({8'b0, cfg_unit});
            home_delay[c] = dsps_pkg::POLL_WAIT;
            home_st[c] = HM_POLL;
        end else begin
            home_delay[c] = dsps_pkg::SETTLE_WAIT;
            home_st[c] = HM_SETTLE;
        end
    endfunction

    function automatic logic home_advance(input int c, input logic sensor);
        if (home_st[c] == HM_IDLE) return 1'b0;
        if (home_st[c] == HM_POLL && home_age[c] != '1) home_age[c] = home_age[c] + 1'b1;
        if (home_delay[c] != '0) home_delay[c] = home_delay[c] - 1'b1;
        if (home_delay[c] != '0) return 1'b0;
        case (home_st[c])
            HM_POLL: begin
                if (home_age[c] > cfg_max_home) begin
                    home_st[c] = HM_IDLE;
                    return 1'b1;
                end
                start_poll(c, sensor);
            end
            HM_SETTLE: begin
                step_cnt[c] = -$signed({9'b0, cfg_unit[15:1]});
                home_delay[c] = cfg_post;
                home_st[c] = (cfg_post == '0) ? HM_IDLE : HM_POST;
            end
            default: home_st[c] = HM_IDLE;
        endcase
        return 1'b0;
    endfunction

    function automatic void step_motor(input int c);
        logic up;
        if (step_cnt[c] == 0) begin
            coil_latch[c] = 4'b0;
            return;
        end
        coil_latch[c] = COIL_SEQ[phase_q[c]*4 +: 4];
        if (step_cnt[c] > 0) begin
            step_cnt[c] = step_cnt[c] - 1'b1;
            up = dir_cfg[c];
        end else begin
            step_cnt[c] = step_cnt[c] + 1'b1;
            up = !dir_cfg[c];
        end
        phase_q[c] = up ? phase_q[c] + 2'd1 : phase_q[c] - 2'd1;
    endfunction

    function automatic dsps_pkg::t_result predict_outputs(input t_request r);
        dsps_pkg::t_result res;
        logic fa;
        logic fb;
        fa = 1'b0;
        fb = 1'b0;
        case (r.opcode)
            dsps_pkg::OP_TICK: begin
                fa = home_advance(CH_A, r.sensor_a);
                fb = home_advance(CH_B, r.sensor_b);
                step_motor(CH_A);
                step_motor(CH_B);
            end
            dsps_pkg::OP_SET: begin
                if (home_st[r.channel] == HM_IDLE) step_cnt[r.channel] = r.target;
            end
            dsps_pkg::OP_HOME: begin
                home_age[r.channel] = '0;
                start_poll(r.channel, r.channel ? r.sensor_b : r.sensor_a);
            end
            default: ;
        endcase
        res.a.coils = coil_latch[CH_A];
        res.a.homing = (home_st[CH_A] != HM_IDLE);
        res.a.fail = fa;
        res.b.coils = coil_latch[CH_B];
        res.b.homing = (home_st[CH_B] != HM_IDLE);
        res.b.fail = fb;
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                drive_expect_q.push_back(predict_outputs({i_opcode, i_channel, i_target_steps,
                                                          i_sensor_a, i_sensor_b}));
                accepted_n <= accepted_n + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    t_request nxt;
                    nxt = cmd_q.pop_front();
                    i_opcode <= nxt.opcode;
                    i_channel <= nxt.channel;
                    i_target_steps <= nxt.target;
                    i_sensor_a <= nxt.sensor_a;
                    i_sensor_b <= nxt.sensor_b;
                    i_in_valid <= 1'b1;
                    gap_left <= idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_n >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                dsps_pkg::t_result got;
                dsps_pkg::t_result want;
                got = {o_coils_a, o_homing_a, o_home_fail_a,
                       o_coils_b, o_homing_b, o_home_fail_b};
                if (drive_expect_q.size() == 0) begin
                    if (mismatch_n < 10)
                        $display("unexpected result: coils a=%h b=%h homing %b%b fail %b%b",
                                 got.a.coils, got.b.coils, got.a.homing, got.b.homing,
                                 got.a.fail, got.b.fail);
                    mismatch_n = mismatch_n + 1;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (got !== want) begin
                        if (mismatch_n < 10)
                            $display({"mismatch: exp coils a=%h b=%h homing %b%b fail %b%b, ",
                                      "got coils a=%h b=%h homing %b%b fail %b%b"},
                                     want.a.coils, want.b.coils, want.a.homing, want.b.homing,
                                     want.a.fail, want.b.fail, got.a.coils, got.b.coils,
                                     got.a.homing, got.b.homing, got.a.fail, got.b.fail);
                        mismatch_n = mismatch_n + 1;
                    end
                end
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
            end
        end
    end

    task automatic push_req(input logic [1:0] op, input logic ch, input int tgt,
                            input logic sa, input logic sb);
        cmd_q.push_back('{op, ch, TARGET_W'(tgt), sa, sb});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_q.size() != 0 || i_in_valid || drive_expect_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            dsps_pkg::REG_UNIT_STEP: cfg_unit = val[UNIT_W-1:0];
            dsps_pkg::REG_MAX_HOME:  cfg_max_home = val[MAXHOME_W-1:0];
            dsps_pkg::REG_POST_HOME: cfg_post = val[WAIT_W-1:0];
            dsps_pkg::REG_DIR_A:     dir_cfg[CH_A] = val[0];
            dsps_pkg::REG_DIR_B:     dir_cfg[CH_B] = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [UNIT_W-1:0] unit,
                                 input logic [MAXHOME_W-1:0] maxh,
                                 input logic [WAIT_W-1:0] post, input logic da, input logic db);
        write_reg(dsps_pkg::REG_UNIT_STEP, CFG_W'(unit));
        write_reg(dsps_pkg::REG_MAX_HOME, CFG_W'(maxh));
        write_reg(dsps_pkg::REG_POST_HOME, CFG_W'(post));
        write_reg(dsps_pkg::REG_DIR_A, CFG_W'(da));
        write_reg(dsps_pkg::REG_DIR_B, CFG_W'(db));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_request random_req();
        t_request r;
        int k;
        k = $urandom_range(0, 99);
        if (k < 68) r.opcode = dsps_pkg::OP_TICK;
        else if (k < 83) r.opcode = dsps_pkg::OP_SET;
        else if (k < 93) r.opcode = dsps_pkg::OP_HOME;
        else r.opcode = OP_NOP;
        r.channel = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            6: r.target = TARGET_W'($urandom());
            7: begin
                case ($urandom_range(0, 4))
                    0: r.target = 24'sh7FFFFF;
                    1: r.target = 24'sh800000;
                    2: r.target = 24'sh000000;
                    3: r.target = 24'sh000001;
                    default: r.target = 24'shFFFFFF;
                endcase
            end
            default: r.target = TARGET_W'(int'($urandom_range(0, 40)) - 20);
        endcase
        // sensors mostly hold their level so homing sequences run their course
        if ($urandom_range(0, 39) == 0) sticky_sa = !sticky_sa;
        if ($urandom_range(0, 39) == 0) sticky_sb = !sticky_sb;
        if ($urandom_range(0, 11) == 0) begin
            r.sensor_a = 1'($urandom_range(0, 1));
            r.sensor_b = 1'($urandom_range(0, 1));
        end else begin
            r.sensor_a = sticky_sa;
            r.sensor_b = sticky_sb;
        end
        return r;
    endfunction

    task automatic run_random_phase(input int n);
        repeat (n) cmd_q.push_back(random_req());
        wait_idle();
    endtask

    initial begin
        cfg_unit = dsps_pkg::UNIT_STEP_RST;
        cfg_max_home = dsps_pkg::MAX_HOME_RST;
        cfg_post = dsps_pkg::POST_HOME_RST;
        for (int c = 0; c < 2; c++) begin
            step_cnt[c] = '0;
            phase_q[c] = 2'd0;
            home_st[c] = HM_IDLE;
            home_delay[c] = '0;
            home_age[c] = '0;
            coil_latch[c] = 4'b0;
            dir_cfg[c] = 1'b1;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, with the reset register values
        push_req(dsps_pkg::OP_SET, 1'b0, 8388607, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_SET, 1'b1, -8388608, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b0, 0, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b1, -1, 1'b0, 1'b0);
        push_req(OP_NOP, 1'b1, -1, 1'b1, 1'b1);
        push_req(dsps_pkg::OP_SET, 1'b0, 0, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_SET, 1'b1, 1, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b0, 0, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b0, 0, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_SET, 1'b0, -3, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b0, 0, 1'b1, 1'b1);
        push_req(dsps_pkg::OP_HOME, 1'b0, 0, 1'b1, 1'b0);
        push_req(dsps_pkg::OP_SET, 1'b0, 77, 1'b1, 1'b0);
        push_req(dsps_pkg::OP_SET, 1'b1, -2, 1'b1, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b0, 0, 1'b1, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b1, 0, 1'b1, 1'b0);
        push_req(dsps_pkg::OP_HOME, 1'b0, 0, 1'b0, 1'b1);
        push_req(dsps_pkg::OP_HOME, 1'b1, 0, 1'b0, 1'b1);
        push_req(dsps_pkg::OP_TICK, 1'b0, 0, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_SET, 1'b1, 9, 1'b0, 1'b0);
        push_req(dsps_pkg::OP_TICK, 1'b1, 0, 1'b1, 1'b1);
        wait_idle();

        apply_setting(16'd1, 20'd0, 16'd0, 1'b1, 1'b0);
        run_random_phase(275);
        apply_setting(16'd5, 20'd40, 16'd3, 1'b0, 1'b0);
        run_random_phase(275);
        apply_setting(16'd65535, 20'd1048575, 16'd65535, 1'b1, 1'b1);
        run_random_phase(275);
        quiet = 1'b1;
        apply_setting(16'd12, 20'd200, 16'd20, 1'b1, 1'b0);
        run_random_phase(275);
        quiet = 1'b0;
        apply_setting(16'd3, 20'd15, 16'd2, 1'b0, 1'b1);
        run_random_phase(275);
        apply_setting(16'd200, 20'd5000, 16'd500, 1'b1, 1'b1);
        run_random_phase(275);

        if (mismatch_n == 0 && drive_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
